@@ hdl/tfn_pkg.sv @@
// Shared constants and types for the triangle face normal unit.
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int POS_W                = 24;
  localparam int NORM_W               = 16;
  localparam int SUM_W                = 64;
  localparam int ROOT_STEPS           = 32;
  localparam int CNT_W                = 6;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CROSS  = 8'b0000_0010,
    ST_MAG    = 8'b0000_0100,
    ST_SHIFT  = 8'b0000_1000,
    ST_SQUARE = 8'b0001_0000,
    ST_ROOT   = 8'b0010_0000,
    ST_DIVIDE = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } tfn_state_e;

endpackage

`default_nettype wire

@@ hdl/triangle_face_normal_unit.sv @@
// Triangle face normal unit: cross product and unit-length normalization per triangle.
//
// Input channel: one vertex per beat (pos_x_i/pos_y_i/pos_z_i, end_of_list_i),
// taken when in_valid_i is high and in_stall_o is low. Every three vertices
// form a triangle. Output channel: normal beats (norm_x_o/y/z, last_of_run_o),
// taken when out_valid_o is high and out_stall_i is low.
// The first and second vertex of a triangle are stored and give no beat. The
// third starts a sequencer around a cross-product multiplier shared by six
// products, a squaring multiplier, a shifter and 64-bit compare/subtract
// logic: cross product, magnitude, a normalizing shift of one bit per step
// (up to 30 bits), sum of squares, square root and a division per component.
// A zero cross product goes from the shift test straight to the beats, with
// a zero normal in them; either way, three beats carry the normal,
// the third marked last. End of list on the first or second vertex gives one
// zero normal per pending vertex. in_stall_o stays high while a triangle is
// worked on and until its last beat is taken; a stalled receiver simply holds
// the block in its emit phase.
// Reset clears the sequencer and the vertex count; the block then takes
// vertices at once.
`default_nettype none

module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [POS_W-1:0]  pos_x_i,
  input  wire logic signed [POS_W-1:0]  pos_y_i,
  input  wire logic signed [POS_W-1:0]  pos_z_i,
  input  wire logic                     end_of_list_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [NORM_W-1:0]      norm_x_o,
  output logic signed [NORM_W-1:0]      norm_y_o,
  output logic signed [NORM_W-1:0]      norm_z_o,
  output logic                          last_of_run_o
);

  localparam int CW = COORD_WIDTH;
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int MW = PW + 1;
  localparam int SW = (MW > 32) ? MW : 32;
  localparam int FB = NORMAL_FRAC_BITS;
  localparam int QW = FB + 1;
  localparam int RW = (QW + 1 > NORM_W) ? QW + 1 : NORM_W;

  localparam logic [1:0]       PHASE_FIRST = 2'd0;
  localparam logic [1:0]       PHASE_THIRD = 2'd2;
  localparam logic [1:0]       COMP_LAST   = 2'd2;
  localparam logic [1:0]       EMIT_ALL    = 2'd3;
  localparam logic [1:0]       EMIT_ONE    = 2'd1;
  localparam logic [CNT_W-1:0] CROSS_LAST  = CNT_W'(6);
  localparam logic [CNT_W-1:0] SQ_LAST     = CNT_W'(3);
  localparam logic [CNT_W-1:0] ROOT_LAST   = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(FB + 2);
  localparam logic [SUM_W-1:0] ROOT_BIT0   = SUM_W'(1) << (SUM_W - 2);

  tfn_state_e state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0] phase_q, emit_q, comp_q;

  logic signed [CW-1:0] v0x_q, v0y_q, v0z_q, v1x_q, v1y_q, v1z_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d1z_q, d2x_q, d2y_q, d2z_q;
  logic signed [PW-1:0] prod_q;
  logic signed [MW-1:0] c0_q, c1_q, c2_q;
  logic [SW-1:0] m0_q, m1_q, m2_q;
  logic neg0_q, neg1_q, neg2_q;
  logic [61:0] sq_q;
  logic [SUM_W-1:0] sum_q, root_q, bit_q, num_q, den_q;
  logic [QW-1:0] quo_q;
  logic [NORM_W-1:0] nrm0_q, nrm1_q, nrm2_q;

  // low COORD_WIDTH bits of each coordinate, two's complement
  logic [XW-1:0] px_ext, py_ext, pz_ext;
  logic signed [CW-1:0] px, py, pz;
  assign px_ext = XW'(unsigned'(pos_x_i));
  assign py_ext = XW'(unsigned'(pos_y_i));
  assign pz_ext = XW'(unsigned'(pos_z_i));
  assign px = signed'(px_ext[CW-1:0]);
  assign py = signed'(py_ext[CW-1:0]);
  assign pz = signed'(pz_ext[CW-1:0]);

  logic in_accept;
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // shared multiplier operands for the cross product
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d;
  always_comb begin
    case (cnt_q)
      CNT_W'(0): begin mul_a = d1y_q; mul_b = d2z_q; end
      CNT_W'(1): begin mul_a = d1z_q; mul_b = d2y_q; end
      CNT_W'(2): begin mul_a = d1z_q; mul_b = d2x_q; end
      CNT_W'(3): begin mul_a = d1x_q; mul_b = d2z_q; end
      CNT_W'(4): begin mul_a = d1x_q; mul_b = d2y_q; end
      CNT_W'(5): begin mul_a = d1y_q; mul_b = d2x_q; end
      default:   begin mul_a = '0;    mul_b = '0;    end
    endcase
  end
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // magnitudes from the cross product
  logic [MW-1:0] a0, a1, a2;
  assign a0 = c0_q[MW-1] ? (~c0_q + MW'(1)) : c0_q;
  assign a1 = c1_q[MW-1] ? (~c1_q + MW'(1)) : c1_q;
  assign a2 = c2_q[MW-1] ? (~c2_q + MW'(1)) : c2_q;

  // normalizing shift tests: at or above 2^31, below 2^30, all zero
  logic m_hi, m_top, m_zero;
  assign m_hi   = |{m0_q[SW-1:31], m1_q[SW-1:31], m2_q[SW-1:31]};
  assign m_top  = |{m0_q[SW-1:30], m1_q[SW-1:30], m2_q[SW-1:30]};
  assign m_zero = ~|{m0_q, m1_q, m2_q};

  // square and divide operand
  logic [SW-1:0] m_sel;
  logic neg_sel;
  always_comb begin
    case (state_q == ST_SQUARE ? cnt_q[1:0] : comp_q)
      2'd0:    begin m_sel = m0_q; neg_sel = neg0_q; end
      2'd1:    begin m_sel = m1_q; neg_sel = neg1_q; end
      2'd2:    begin m_sel = m2_q; neg_sel = neg2_q; end
      default: begin m_sel = '0;   neg_sel = 1'b0;   end
    endcase
  end

  logic [61:0] sq_d;
  assign sq_d = 62'(m_sel[30:0]) * 62'(m_sel[30:0]);

  logic [SUM_W-1:0] trial;
  assign trial = root_q + bit_q;

  // final quotient: clamp, sign, wrap to the output width
  logic [QW-1:0] one_q, q_clamp;
  logic [RW-1:0] q_ext, q_signed;
  assign one_q    = QW'(1) << FB;
  assign q_clamp  = (quo_q > one_q) ? one_q : quo_q;
  assign q_ext    = RW'(q_clamp);
  assign q_signed = neg_sel ? (~q_ext + RW'(1)) : q_ext;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      phase_q <= PHASE_FIRST;
      emit_q  <= '0;
      comp_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (phase_q == PHASE_THIRD) begin
              phase_q <= PHASE_FIRST;
              cnt_q   <= '0;
              state_q <= ST_CROSS;
            end else if (end_of_list_i) begin
              emit_q  <= phase_q + 2'd1;
              phase_q <= PHASE_FIRST;
              state_q <= ST_EMIT;
            end else begin
              phase_q <= phase_q + 2'd1;
            end
          end
        end
        ST_CROSS: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CROSS_LAST) state_q <= ST_MAG;
        end
        ST_MAG: begin
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!m_hi && m_zero) begin
            emit_q  <= EMIT_ALL;
            state_q <= ST_EMIT;
          end else if (!m_hi && m_top) begin
            cnt_q   <= '0;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == SQ_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == ROOT_LAST) begin
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == DIV_LAST) begin
            cnt_q <= '0;
            if (comp_q == COMP_LAST) begin
              emit_q  <= EMIT_ALL;
              state_q <= ST_EMIT;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            emit_q <= emit_q - 2'd1;
            if (emit_q == EMIT_ONE) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          nrm0_q <= '0;
          nrm1_q <= '0;
          nrm2_q <= '0;
          if (phase_q == PHASE_THIRD) begin
            d1x_q <= DW'(v1x_q) - DW'(v0x_q);
            d1y_q <= DW'(v1y_q) - DW'(v0y_q);
            d1z_q <= DW'(v1z_q) - DW'(v0z_q);
            d2x_q <= DW'(px) - DW'(v1x_q);
            d2y_q <= DW'(py) - DW'(v1y_q);
            d2z_q <= DW'(pz) - DW'(v1z_q);
          end else if (phase_q == PHASE_FIRST) begin
            v0x_q <= px;
            v0y_q <= py;
            v0z_q <= pz;
          end else begin
            v1x_q <= px;
            v1y_q <= py;
            v1z_q <= pz;
          end
        end
      end
      ST_CROSS: begin
        prod_q <= prod_d;
        case (cnt_q)
          CNT_W'(1): c0_q <= MW'(prod_q);
          CNT_W'(2): c0_q <= c0_q - MW'(prod_q);
          CNT_W'(3): c1_q <= MW'(prod_q);
          CNT_W'(4): c1_q <= c1_q - MW'(prod_q);
          CNT_W'(5): c2_q <= MW'(prod_q);
          CNT_W'(6): c2_q <= c2_q - MW'(prod_q);
          default: ;
        endcase
      end
      ST_MAG: begin
        neg0_q <= c0_q[MW-1];
        neg1_q <= c1_q[MW-1];
        neg2_q <= c2_q[MW-1];
        m0_q   <= SW'(a0);
        m1_q   <= SW'(a1);
        m2_q   <= SW'(a2);
      end
      ST_SHIFT: begin
        if (m_hi) begin
          m0_q <= m0_q >> 1;
          m1_q <= m1_q >> 1;
          m2_q <= m2_q >> 1;
        end else if (!m_top && !m_zero) begin
          m0_q <= m0_q << 1;
          m1_q <= m1_q << 1;
          m2_q <= m2_q << 1;
        end
      end
      ST_SQUARE: begin
        sq_q <= sq_d;
        if (cnt_q == CNT_W'(1)) sum_q <= SUM_W'(sq_q);
        else if (cnt_q != '0) sum_q <= sum_q + SUM_W'(sq_q);
        root_q <= '0;
        bit_q  <= ROOT_BIT0;
      end
      ST_ROOT: begin
        // digit-by-digit root, sum_q holds the remainder
        if (sum_q >= trial) begin
          sum_q  <= sum_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIVIDE: begin
        if (cnt_q == '0) begin
          num_q <= (SUM_W'(m_sel[30:0]) << FB) + (root_q >> 1);
          den_q <= root_q << FB;
          quo_q <= '0;
        end else if (cnt_q == DIV_LAST) begin
          case (comp_q)
            2'd0:    nrm0_q <= q_signed[NORM_W-1:0];
            2'd1:    nrm1_q <= q_signed[NORM_W-1:0];
            default: nrm2_q <= q_signed[NORM_W-1:0];
          endcase
        end else begin
          if (num_q >= den_q) begin
            num_q <= num_q - den_q;
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          den_q <= den_q >> 1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = (state_q == ST_EMIT);
  assign norm_x_o      = signed'(nrm0_q);
  assign norm_y_o      = signed'(nrm1_q);
  assign norm_z_o      = signed'(nrm2_q);
  assign last_of_run_o = (emit_q == EMIT_ONE);

endmodule

`default_nettype wire

@@ hdl/tfn_checker.sv @@
// Port-level checks for the triangle face normal unit, bound to the top level.
`default_nettype none

module tfn_checker import tfn_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic signed [POS_W-1:0] pos_x_i,
  input wire logic signed [POS_W-1:0] pos_y_i,
  input wire logic signed [POS_W-1:0] pos_z_i,
  input wire logic                    end_of_list_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic signed [NORM_W-1:0] norm_x_o,
  input wire logic signed [NORM_W-1:0] norm_y_o,
  input wire logic signed [NORM_W-1:0] norm_z_o,
  input wire logic                    last_of_run_o
);

  // a beat waiting on the output keeps vertices out
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("vertex channel open while a normal beat is pending");

  // end of list always produces output work before the next vertex
  a_eol_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && end_of_list_i) |=> in_stall_o)
    else $error("end of list did not start a run");

  // the marked beat closes the run
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_run_o) |=> !out_valid_o)
    else $error("beat after the last of a run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(norm_x_o) && $stable(norm_y_o) && $stable(norm_z_o)
       && $stable(last_of_run_o)))
    else $error("output payload changed while stalled");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);

`default_nettype wire

@@ bench/tfn_checker.sv @@
// Checker for the triangle face normal unit: watches both channels, predicts normals, compares.
`timescale 1ns / 100ps
`default_nettype none

module tfn_scoreboard import tfn_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic signed [POS_W-1:0] pos_z_i,
  input  wire logic                    end_of_list_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic signed [NORM_W-1:0] norm_x_i,
  input  wire logic signed [NORM_W-1:0] norm_y_i,
  input  wire logic signed [NORM_W-1:0] norm_z_i,
  input  wire logic                    last_of_run_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           beats_o
);

  typedef struct packed {
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nz;
    logic              last;
  } normal_beat_t;

  normal_beat_t expected_normals[$];
  longint       held_pos[6];
  int           pending_verts;

  assign pending_o = expected_normals.size();

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= root + bit_v) begin
        s -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  // cross product scaled to unit length, components as 16-bit two's complement
  function automatic void face_normal(input longint cr[3], output logic [NORM_W-1:0] nv[3]);
    longint unsigned mag[3], mx, sum, len, q, one;
    bit neg[3];
    mx = 0;
    sum = 0;
    one = 64'd1 << NORMAL_FRAC_BITS_DEF;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) nv[i] = '0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << NORMAL_FRAC_BITS_DEF) + (len >> 1)) / len;
      if (q > one) q = one;
      nv[i] = NORM_W'(neg[i] ? -q : q);
    end
  endfunction

  task automatic take_vertex(longint px, longint py, longint pz, bit eol);
    longint d1[3], d2[3], cr[3], p[3];
    logic [NORM_W-1:0] nv[3];
    normal_beat_t b;
    p[0] = px; p[1] = py; p[2] = pz;
    if (pending_verts == 2) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] = held_pos[3+i] - held_pos[i];
        d2[i] = p[i] - held_pos[3+i];
      end
      cr[0] = d1[1]*d2[2] - d1[2]*d2[1];
      cr[1] = d1[2]*d2[0] - d1[0]*d2[2];
      cr[2] = d1[0]*d2[1] - d1[1]*d2[0];
      face_normal(cr, nv);
      for (int k = 0; k < 3; k++) begin
        b = '{nv[0], nv[1], nv[2], k == 2};
        expected_normals = {expected_normals, b};
      end
      pending_verts = 0;
    end else begin
      for (int i = 0; i < 3; i++) held_pos[pending_verts*3+i] = p[i];
      if (!eol) begin
        pending_verts++;
      end else begin
        // flush pending vertices with zero normals
        for (int k = 0; k <= pending_verts; k++) begin
          b = '{'0, '0, '0, k == pending_verts};
          expected_normals = {expected_normals, b};
        end
        pending_verts = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    normal_beat_t want;
    if (!rst_ni) begin
      errors_o <= 0;
      beats_o <= 0;
      pending_verts = 0;
      for (int i = 0; i < 6; i++) held_pos[i] = 0;
      expected_normals.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        beats_o <= beats_o + 1;
        if (expected_normals.size() == 0) begin
          $error("unexpected normal beat x=%0d y=%0d z=%0d", norm_x_i, norm_y_i, norm_z_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_normals.pop_front();
          if (norm_x_i !== want.nx || norm_y_i !== want.ny || norm_z_i !== want.nz ||
              last_of_run_i !== want.last) begin
            if (norm_x_i !== want.nx)
              $error("norm_x expected %0d got %0d", $signed(want.nx), norm_x_i);
            if (norm_y_i !== want.ny)
              $error("norm_y expected %0d got %0d", $signed(want.ny), norm_y_i);
            if (norm_z_i !== want.nz)
              $error("norm_z expected %0d got %0d", $signed(want.nz), norm_z_i);
            if (last_of_run_i !== want.last)
              $error("last_of_run expected %0b got %0b", want.last, last_of_run_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        take_vertex(pos_x_i, pos_y_i, pos_z_i, end_of_list_i);
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench top for the triangle face normal unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none

module tb_top import tfn_pkg::*; ();

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic end_of_list_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [NORM_W-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic last_of_run_o;
  int errors, pending, beats;
  int send_idle_pct, recv_idle_pct;
  int vertices_sent;

  always #1 clk_i = ~clk_i;

  triangle_face_normal_unit dut (.*);

  tfn_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .end_of_list_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .norm_x_i(norm_x_o), .norm_y_i(norm_y_o), .norm_z_i(norm_z_o),
    .last_of_run_i(last_of_run_o),
    .errors_o(errors), .pending_o(pending), .beats_o(beats)
  );

  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // valid drops only while idling, so back-to-back beats keep it high
  task automatic send_vertex(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, bit eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    end_of_list_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vertices_sent++;
  endtask

  function automatic logic [POS_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return POS_W'($urandom_range(15)) - POS_W'(8);
      3: return POS_W'($urandom_range(2000)) - POS_W'(1000);
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic send_triangle(bit eol);
    logic [POS_W-1:0] x, y, z;
    x = rand_coord(); y = rand_coord(); z = rand_coord();
    send_vertex(x, y, z, 1'b0);
    // sometimes a repeated vertex for a degenerate face
    if ($urandom_range(9) == 0) send_vertex(x, y, z, 1'b0);
    else send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0);
    send_vertex(rand_coord(), rand_coord(), rand_coord(), eol);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    vertices_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: unit axes, extremes, degenerate face, short lists
    send_vertex(0, 0, 0, 0); send_vertex(1, 0, 0, 0); send_vertex(1, 1, 0, 0);
    send_vertex(0, 0, 0, 0); send_vertex(0, 0, 1, 0); send_vertex(0, 1, 1, 0);
    send_vertex(24'h800000, 24'h800000, 24'h800000, 0);
    send_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 0);
    send_vertex(24'h800000, 24'h7fffff, 24'h7fffff, 1);
    send_vertex(5, 5, 5, 0); send_vertex(5, 5, 5, 0); send_vertex(5, 5, 5, 0);
    send_vertex(3, 4, 5, 0); send_vertex(6, 8, 10, 0); send_vertex(9, 12, 15, 0);
    send_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff, 1);
    send_vertex(-7, 2, 9, 0); send_vertex(24'h800000, 0, 24'h7fffff, 1);
    send_vertex(-1, -1, -1, 0); send_vertex(2, -3, 4, 0); send_vertex(-5, 6, -7, 1);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 34 : 0;
      for (int t = 0; t < 46; t++) begin
        case ($urandom_range(9))
          0: send_vertex(rand_coord(), rand_coord(), rand_coord(), 1);
          1: send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
          default: send_triangle($urandom_range(7) == 0);
        endcase
        // hold off until everything has drained
        if (t == 20) begin
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d vertices, %0d normal beats checked, under three idling mixes.",
             vertices_sent, beats);
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
